>>> sv/itoa_pkg.sv
// itoa_pkg: shared types, constants and character helpers for the integer to ASCII block.
// Used by itoa_divider and integer_to_ascii_radix_top; depends on nothing.
package itoa_pkg;

	localparam int MAX_DIGITS = 32;
	localparam int VALUE_W    = 64;
	localparam int NARROW_W   = 32;
	localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
	localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int BIT_CNT_W  = $clog2(VALUE_W);
	localparam int RADIX_W    = 5;
	localparam int CHAR_W     = 8;
	localparam int COUNT_W    = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [1:0] MODE_SDEC = 2'd0;
	localparam logic [1:0] MODE_URAD = 2'd1;
	localparam logic [1:0] MODE_HEX  = 2'd2;
	localparam logic [1:0] MODE_PTR  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd2;

	localparam logic [63:0] CHARS_LOW_RST  = 64'h3736353433323130;
	localparam logic [63:0] CHARS_HIGH_RST = 64'h6665646362613938;
	localparam logic [RADIX_W-1:0] RADIX_RST = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
	localparam logic [CHAR_W-1:0] CH_N     = 8'h6e;
	localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
	localparam logic [CHAR_W-1:0] CH_L     = 8'h6c;
	localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
	localparam logic [CHAR_W-1:0] CH_A_OFS = 8'h57;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREFIX,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_RD,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PRE_NONE,
		PRE_MINUS,
		PRE_HEX,
		PRE_NIL
	} prefix_t;

	typedef struct packed {
		logic start;
		logic wide;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	function automatic logic [CHAR_W-1:0] lower_hex_char(input logic [3:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {4'b0, d};
		return (d < 4'd10) ? CH_ZERO + dx : CH_A_OFS + dx;
	endfunction

	function automatic logic [CHAR_W-1:0] alphabet_char(input logic [63:0] lo,
		input logic [63:0] hi, input logic [3:0] d);
		logic [127:0] alpha;
		alpha = {hi, lo};
		return alpha[{d, 3'b000} +: CHAR_W];
	endfunction

	function automatic logic [CHAR_W-1:0] prefix_char(input prefix_t kind,
		input logic [2:0] idx);
		logic [CHAR_W-1:0] c;
		c = CH_MINUS;
		unique case (kind)
			PRE_HEX: c = (idx == 3'd0) ? CH_ZERO : CH_X;
			PRE_NIL: begin
				unique case (idx)
					3'd0: c = CH_LPAR;
					3'd1: c = CH_N;
					3'd2: c = CH_I;
					3'd3: c = CH_L;
					default: c = CH_RPAR;
				endcase
			end
			default: c = CH_MINUS;
		endcase
		return c;
	endfunction

endpackage

>>> sv/itoa_divider.sv
// itoa_divider: restoring divider, one quotient bit per cycle, by a radix of 2 to 16.
// Depends on itoa_pkg.
module itoa_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  itoa_pkg::div_ctl_t           ctl,
	input  logic [itoa_pkg::RADIX_W-1:0] radix,
	input  logic [itoa_pkg::VALUE_W-1:0] dividend,
	output itoa_pkg::div_sts_t           sts,
	output logic [itoa_pkg::VALUE_W-1:0] quotient,
	output logic [3:0]                   remainder
);
	import itoa_pkg::*;

	logic [VALUE_W-1:0]   work_q;
	logic [3:0]           rem_q;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic                 wide_q;
	logic                 busy_q;
	logic                 done_q;

	logic                 msb;
	logic [RADIX_W-1:0]   trial;
	logic                 qbit;
	logic [3:0]           rem_d;
	logic [VALUE_W-1:0]   work_d;

	always_comb begin
		msb    = wide_q ? work_q[VALUE_W-1] : work_q[NARROW_W-1];
		trial  = {rem_q, msb};
		qbit   = (trial >= radix);
		rem_d  = qbit ? 4'(trial - radix) : trial[3:0];
		work_d = wide_q ? {work_q[VALUE_W-2:0], qbit}
			: {{(VALUE_W-NARROW_W){1'b0}}, work_q[NARROW_W-2:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			wide_q <= 1'b0;
			work_q <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				wide_q <= ctl.wide;
				work_q <= dividend;
				rem_q  <= '0;
				cnt_q  <= ctl.wide ? BIT_CNT_W'(VALUE_W - 1) : BIT_CNT_W'(NARROW_W - 1);
			end else if (busy_q) begin
				work_q <= work_d;
				rem_q  <= rem_d;
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = work_q;
	assign remainder = rem_q;

endmodule

>>> sv/integer_to_ascii_radix_top.sv
// integer_to_ascii_radix_top: converts a number to ASCII text, one character per output transfer.
// Depends on itoa_pkg and itoa_divider.
//
// usage
// s_tdata carries the value, s_tuser the mode (0 signed decimal, 1 unsigned in the
// configured radix, 2 64-bit hex, 3 pointer). s_tready is high only while idle.
// m_tdata carries the character in bits 7..0 and the running character count in
// bits 39..8; m_tlast marks the final character of a conversion.
// cfg_valid/cfg_ready write cfg_data to register cfg_index (0 low alphabet, 1 high
// alphabet, 2 radix); cfg_ready is always high, write only while idle.
// timing: each digit takes one pass of the shared bit-serial divider, over 32 bits for
// modes 0 and 1 and 64 bits for modes 2 and 3; each character is then read out of the
// digit memory (ST_RD) before it is emitted (ST_EMIT), prefix characters go out directly.
// The first character is loaded into the output register from ST_PREFIX for a prefixed
// value, otherwise only after the whole digit split.
// reset clears the state machine, the output valid flag and the character count and
// loads the default alphabet "0123456789abcdef" and radix 10.
// when the receiver stalls the held character stays on m_tdata and the block waits before loading its next character.
module integer_to_ascii_radix_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [63:0]                    s_tdata,   // value[63:0]
	input  logic [1:0]                     s_tuser,   // mode[1:0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [39:0]                    m_tdata,   // out_char[7:0], total_count[39:8]
	output logic                           m_tlast,   // last
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [itoa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data
);
	import itoa_pkg::*;

	state_t               state_q, state_d;
	logic [63:0]          chars_low_q, chars_high_q;
	logic [RADIX_W-1:0]   radix_cfg_q;
	logic [COUNT_W-1:0]   char_cnt_q;

	logic [1:0]           mode_q;
	logic [RADIX_W-1:0]   radix_q;
	logic [VALUE_W-1:0]   work_q;
	prefix_t              pre_kind_q;
	logic [2:0]           pre_idx_q;
	logic [DIG_CNT_W-1:0] dig_total_q;
	logic [DIG_CNT_W-1:0] emit_idx_q;

	logic [3:0]           dig_mem [MAX_DIGITS];
	logic [3:0]           rd_data_q;
	logic [DIG_CNT_W-1:0] rd_ptr;

	logic                 m_valid_q;
	logic [CHAR_W-1:0]    m_char_q;
	logic                 m_last_q;
	logic [COUNT_W-1:0]   m_count_q;

	div_ctl_t             div_ctl;
	div_sts_t             div_sts;
	logic [VALUE_W-1:0]   div_quot;
	logic [3:0]           div_rem;

	logic                 accept;
	logic                 out_free;
	logic                 out_load;
	logic [CHAR_W-1:0]    out_char_d;
	logic                 out_last_d;
	logic                 pre_end;
	logic                 dig_we;
	logic                 split_end;
	logic [DIG_CNT_W-1:0] dig_next;

	logic [NARROW_W-1:0]  in_low;
	logic [NARROW_W-1:0]  in_mag;
	logic [VALUE_W-1:0]   in_work;
	prefix_t              in_pre;
	logic [RADIX_W-1:0]   in_radix;
	logic [RADIX_W-1:0]   radix_clamp;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign rd_ptr    = emit_idx_q - 1'b1;
	assign dig_next  = dig_total_q + 1'b1;

	always_comb begin
		in_low = s_tdata[NARROW_W-1:0];
		in_mag = in_low[NARROW_W-1] ? NARROW_W'(-in_low) : in_low;
		radix_clamp = (radix_cfg_q < RADIX_MIN) ? RADIX_MIN
			: (radix_cfg_q > RADIX_MAX) ? RADIX_MAX : radix_cfg_q;
		in_work  = s_tdata;
		in_pre   = PRE_NONE;
		in_radix = RADIX_MAX;
		unique case (s_tuser)
			MODE_SDEC: begin
				in_work  = {{(VALUE_W-NARROW_W){1'b0}}, in_mag};
				in_pre   = in_low[NARROW_W-1] ? PRE_MINUS : PRE_NONE;
				in_radix = RADIX_DEC;
			end
			MODE_URAD: begin
				in_work  = {{(VALUE_W-NARROW_W){1'b0}}, in_low};
				in_radix = radix_clamp;
			end
			MODE_HEX: in_pre = PRE_NONE;
			default: in_pre = (s_tdata == '0) ? PRE_NIL : PRE_HEX;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_pre == PRE_NONE) ? ST_DIV_START : ST_PREFIX;
				end
			end
			ST_PREFIX: begin
				if (out_free && pre_end) begin
					state_d = (pre_kind_q == PRE_NIL) ? ST_IDLE : ST_DIV_START;
				end
			end
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_sts.done) begin
					state_d = split_end ? ST_RD : ST_DIV_START;
				end
			end
			ST_RD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = (emit_idx_q == DIG_CNT_W'(1)) ? ST_IDLE : ST_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready      = (state_q == ST_IDLE);
		div_ctl.start = (state_q == ST_DIV_START);
		div_ctl.wide  = mode_q[1];
		pre_end       = (pre_kind_q == PRE_NIL) ? (pre_idx_q == 3'd4)
			: (pre_kind_q == PRE_HEX) ? (pre_idx_q == 3'd1) : 1'b1;
		split_end     = (div_quot == '0) || (dig_next == DIG_CNT_W'(MAX_DIGITS));
		dig_we        = (state_q == ST_DIV_WAIT) && div_sts.done;
		out_load      = 1'b0;
		out_char_d    = prefix_char(pre_kind_q, pre_idx_q);
		out_last_d    = 1'b0;
		unique case (state_q)
			ST_PREFIX: begin
				out_load   = out_free;
				out_last_d = (pre_kind_q == PRE_NIL) && pre_end;
			end
			ST_EMIT: begin
				out_load   = out_free;
				out_char_d = (mode_q == MODE_PTR) ? lower_hex_char(rd_data_q)
					: alphabet_char(chars_low_q, chars_high_q, rd_data_q);
				out_last_d = (emit_idx_q == DIG_CNT_W'(1));
			end
			default: out_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			chars_low_q  <= CHARS_LOW_RST;
			chars_high_q <= CHARS_HIGH_RST;
			radix_cfg_q  <= RADIX_RST;
			char_cnt_q   <= '0;
			m_valid_q    <= 1'b0;
			work_q       <= '0;
			dig_total_q  <= '0;
			emit_idx_q   <= '0;
			pre_idx_q    <= '0;
			pre_kind_q   <= PRE_NONE;
			mode_q       <= MODE_SDEC;
			radix_q      <= RADIX_RST;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_CHARS_LOW:  chars_low_q  <= cfg_data;
					CFG_CHARS_HIGH: chars_high_q <= cfg_data;
					CFG_RADIX:      radix_cfg_q  <= cfg_data[RADIX_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				mode_q      <= s_tuser;
				radix_q     <= in_radix;
				work_q      <= in_work;
				pre_kind_q  <= in_pre;
				pre_idx_q   <= '0;
				dig_total_q <= '0;
			end
			if (state_q == ST_PREFIX && out_free) begin
				pre_idx_q <= pre_idx_q + 1'b1;
			end
			if (dig_we) begin
				work_q      <= div_quot;
				dig_total_q <= dig_next;
				emit_idx_q  <= dig_next;
			end
			if (state_q == ST_EMIT && out_free) begin
				emit_idx_q <= rd_ptr;
			end
			if (out_load) begin
				m_valid_q  <= 1'b1;
				char_cnt_q <= char_cnt_q + 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_char_q  <= out_char_d;
			m_last_q  <= out_last_d;
			m_count_q <= char_cnt_q + 1'b1;
		end
	end

	// digit memory
	always_ff @(posedge clk) begin
		if (dig_we) begin
			dig_mem[dig_total_q[DIG_IDX_W-1:0]] <= div_rem;
		end
		rd_data_q <= dig_mem[rd_ptr[DIG_IDX_W-1:0]];
	end

	itoa_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.radix     (radix_q),
		.dividend  (work_q),
		.sts       (div_sts),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_count_q, m_char_q};
	assign m_tlast  = m_last_q;

endmodule
